### rtl/mfdf_pkg.sv
// shared constants, register indexes and control word types for the flanger delay block
// no dependencies; used by the interfaces, the sequencer and the top level
package mfdf_pkg;

  // delay line depth, a power of two (256 up to 65536)
  localparam int LINE_DEPTH  = 65536;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  // smoothing factor 0.001 as 66/65536
  localparam int SMOOTH_COEF = 66;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // shared multiplier shape
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 18;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 8'd3;

  localparam logic MODE_FLANGER = 1'b0;
  localparam logic MODE_PLAIN   = 1'b1;

  localparam logic [15:0] MOD_DEPTH_RST = 16'd58982;
  localparam logic [15:0] FB_GAIN_RST   = 16'd13107;

  typedef enum logic [2:0] {
    MUL_OFF,
    MUL_SMOOTH,
    MUL_DEPTH,
    MUL_QHI,
    MUL_QLO,
    MUL_INTERP,
    MUL_FB
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_DIFF,
    ACC_BASE,
    ACC_ADD_MOD
  } acc_op_t;

  typedef enum logic [1:0] {
    MOD_HOLD,
    MOD_LOAD_HI,
    MOD_ADD_LO
  } mod_op_t;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_READ_A,
    MEM_READ_B,
    MEM_WRITE
  } mem_op_t;

  // datapath part of one control word
  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    mod_op_t  mod_op;
    mem_op_t  mem_op;
    logic     ld_sd;
    logic     ld_lo;
    logic     ld_addr;
    logic     ld_a;
    logic     ld_y;
    logic     in_rdy;
    logic     commit;
  } dp_ctl_t;

  // status seen by the sequencer for its wait and jump conditions
  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic out_busy;
    logic plain_mode;
  } seq_cond_t;

endpackage

### rtl/mfdf_if.sv
// valid/ready channel interfaces: input samples, results and configuration writes
// depends on mfdf_pkg for the payload widths
interface mfdf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mfdf_pkg::SAMPLE_W-1:0]   sample_in;
  logic signed [mfdf_pkg::SAMPLE_W-1:0]   mod_value;

  modport source (output valid, output sample_in, output mod_value, input ready);
  modport sink (input valid, input sample_in, input mod_value, output ready);
endinterface

interface mfdf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mfdf_pkg::SAMPLE_W-1:0]   sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface mfdf_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [mfdf_pkg::CFG_IDX_W-1:0]         index;
  logic [mfdf_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mfdf_seq.sv
// microcode sequencer: step counter, control store and wait/jump handling
// depends on mfdf_pkg for the control word and condition types
module mfdf_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfdf_pkg::seq_cond_t  cond,
  output mfdf_pkg::dp_ctl_t    ctl
);

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] ST_CLEAR  = 5'd0;
  localparam logic [STEP_W-1:0] ST_WAIT   = 5'd1;
  localparam logic [STEP_W-1:0] ST_DIFF   = 5'd2;
  localparam logic [STEP_W-1:0] ST_SMUL   = 5'd3;
  localparam logic [STEP_W-1:0] ST_SUPD   = 5'd4;
  localparam logic [STEP_W-1:0] ST_DEPTH  = 5'd5;
  localparam logic [STEP_W-1:0] ST_QHI    = 5'd6;
  localparam logic [STEP_W-1:0] ST_QLO    = 5'd7;
  localparam logic [STEP_W-1:0] ST_QSUM   = 5'd8;
  localparam logic [STEP_W-1:0] ST_DADD   = 5'd9;
  localparam logic [STEP_W-1:0] ST_ADDR   = 5'd10;
  localparam logic [STEP_W-1:0] ST_RDA    = 5'd11;
  localparam logic [STEP_W-1:0] ST_RDB    = 5'd12;
  localparam logic [STEP_W-1:0] ST_INTERP = 5'd13;
  localparam logic [STEP_W-1:0] ST_YSUM   = 5'd14;
  localparam logic [STEP_W-1:0] ST_FBMUL  = 5'd15;
  localparam logic [STEP_W-1:0] ST_WB     = 5'd16;

  typedef enum logic [1:0] {
    W_NONE,
    W_CLEAR,
    W_INPUT,
    W_OUT
  } wait_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_PLAIN
  } jmp_t;

  typedef struct packed {
    mfdf_pkg::dp_ctl_t dp;
    wait_t             wt;
    jmp_t              jc;
    logic [STEP_W-1:0] tgt;
  } ucode_t;

  // control store
  function automatic ucode_t rom_word(input logic [STEP_W-1:0] s);
    ucode_t u;
    u = '0;
    unique case (s)
      ST_CLEAR: begin
        u.dp.mem_op = mfdf_pkg::MEM_CLEAR;
        u.wt        = W_CLEAR;
      end
      ST_WAIT: begin
        u.dp.in_rdy = 1'b1;
        u.wt        = W_INPUT;
      end
      ST_DIFF:   u.dp.acc_op  = mfdf_pkg::ACC_DIFF;
      ST_SMUL:   u.dp.mul_sel = mfdf_pkg::MUL_SMOOTH;
      ST_SUPD:   u.dp.ld_sd   = 1'b1;
      ST_DEPTH: begin
        u.dp.mul_sel = mfdf_pkg::MUL_DEPTH;
        u.dp.acc_op  = mfdf_pkg::ACC_BASE;
        u.jc         = J_PLAIN;
        u.tgt        = ST_ADDR;
      end
      ST_QHI: begin
        u.dp.mul_sel = mfdf_pkg::MUL_QHI;
        u.dp.ld_lo   = 1'b1;
      end
      ST_QLO: begin
        u.dp.mul_sel = mfdf_pkg::MUL_QLO;
        u.dp.mod_op  = mfdf_pkg::MOD_LOAD_HI;
      end
      ST_QSUM:   u.dp.mod_op  = mfdf_pkg::MOD_ADD_LO;
      ST_DADD:   u.dp.acc_op  = mfdf_pkg::ACC_ADD_MOD;
      ST_ADDR:   u.dp.ld_addr = 1'b1;
      ST_RDA:    u.dp.mem_op  = mfdf_pkg::MEM_READ_A;
      ST_RDB: begin
        u.dp.mem_op = mfdf_pkg::MEM_READ_B;
        u.dp.ld_a   = 1'b1;
      end
      ST_INTERP: u.dp.mul_sel = mfdf_pkg::MUL_INTERP;
      ST_YSUM:   u.dp.ld_y    = 1'b1;
      ST_FBMUL:  u.dp.mul_sel = mfdf_pkg::MUL_FB;
      ST_WB: begin
        u.dp.mem_op = mfdf_pkg::MEM_WRITE;
        u.dp.commit = 1'b1;
        u.wt        = W_OUT;
        u.jc        = J_ALWAYS;
        u.tgt       = ST_WAIT;
      end
      default: begin
        u.jc  = J_ALWAYS;
        u.tgt = ST_WAIT;
      end
    endcase
    return u;
  endfunction

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ucode_t            uc;
  logic              hold;
  logic              jump;

  always_comb begin
    uc = rom_word(step_r);
    unique case (uc.wt)
      W_NONE:  hold = 1'b0;
      W_CLEAR: hold = !cond.clr_last;
      W_INPUT: hold = !cond.in_valid;
      W_OUT:   hold = cond.out_busy;
    endcase
    jump = (uc.jc == J_ALWAYS) || ((uc.jc == J_PLAIN) && cond.plain_mode);

    ctl = uc.dp;
    if (hold) begin
      ctl.commit = 1'b0;
      if (uc.dp.mem_op == mfdf_pkg::MEM_WRITE) begin
        ctl.mem_op = mfdf_pkg::MEM_IDLE;
      end
    end

    if (hold) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = uc.tgt;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### rtl/modulated_fractional_delay_feedback.sv
// top level of the flanger / plain delay block: config registers, datapath and delay line
// depends on mfdf_pkg, the channel interfaces in mfdf_if and the sequencer mfdf_seq

// Flanger with a 65536-word interpolated delay line and feedback. Each input transfer
// carries one Q1.15 sample and one Q1.15 LFO value and yields exactly one Q1.15 result.
// After reset the block sweeps the delay line to zero, one word a cycle; input ready
// stays low during that sweep, configuration writes are taken at any time. A
// microcoded sequence drives one shared 34x18 multiplier for the smoothing,
// modulation, interpolation and feedback products, and the single delay-line port
// serves both taps and the write back in turn. The result sits in an output register,
// so the next sample may be accepted while it waits. Configuration must be written by
// the user only while the block is idle; the block itself does not enforce this.
module modulated_fractional_delay_feedback (
  input  logic             clk,
  input  logic             rst_n,
  mfdf_in_if.sink          in_ch,
  mfdf_out_if.source       out_ch,
  mfdf_cfg_if.sink         cfg_ch
);

  localparam int AW = mfdf_pkg::LINE_AW;

  // configuration registers
  logic        mode_r;
  logic [31:0] target_r;
  logic [15:0] depth_r;
  logic [15:0] gain_r;

  // captured input sample and lfo value
  logic signed [15:0] x_r;
  logic signed [15:0] lfo_r;

  // algorithm state
  logic [31:0]   sd_r;
  logic [AW-1:0] wp_r;
  logic [AW-1:0] clr_cnt_r;

  // working registers
  logic signed [34:0]                  acc_r;
  logic signed [mfdf_pkg::PROD_W-1:0]  prod_r;
  logic signed [63:0]                  mod_r;
  logic [23:0]                         lo_r;
  logic [AW-1:0]                       ia_r;
  logic [15:0]                         frac_r;
  logic signed [15:0]                  a_r;
  logic signed [15:0]                  y_r;
  logic signed [15:0]                  rdata_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] out_data_r;

  // delay line
  logic [15:0] line_mem [mfdf_pkg::LINE_DEPTH];

  mfdf_pkg::dp_ctl_t   ctl;
  mfdf_pkg::seq_cond_t seq_cond;

  logic in_fire;
  logic cfg_fire;

  // ---------------------------------------------------------------- sequencer
  assign seq_cond.clr_last   = &clr_cnt_r;
  assign seq_cond.in_valid   = in_ch.valid;
  assign seq_cond.out_busy   = out_valid_r && !out_ch.ready;
  assign seq_cond.plain_mode = (mode_r == mfdf_pkg::MODE_PLAIN);

  mfdf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (seq_cond),
    .ctl   (ctl)
  );

  assign in_ch.ready  = ctl.in_rdy;
  assign in_fire      = in_ch.valid && ctl.in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mfdf_pkg::MODE_FLANGER;
      target_r <= '0;
      depth_r  <= mfdf_pkg::MOD_DEPTH_RST;
      gain_r   <= mfdf_pkg::FB_GAIN_RST;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        mfdf_pkg::CFG_MODE:          mode_r   <= cfg_ch.data[0];
        mfdf_pkg::CFG_TARGET_DELAY:  target_r <= cfg_ch.data;
        mfdf_pkg::CFG_MOD_DEPTH:     depth_r  <= cfg_ch.data[15:0];
        mfdf_pkg::CFG_FEEDBACK_GAIN: gain_r   <= cfg_ch.data[15:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [mfdf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mfdf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mfdf_pkg::PROD_W-1:0]  mul_p;
  logic signed [16:0]                  tap_diff;
  logic signed [mfdf_pkg::MUL_B_W-1:0] lfo_ext;

  assign tap_diff = 17'(rdata_r) - 17'(a_r);
  assign lfo_ext  = {{2{lfo_r[15]}}, lfo_r};

  always_comb begin
    case (ctl.mul_sel)
      mfdf_pkg::MUL_SMOOTH: begin
        // target minus smoothed delay, times the smoothing coefficient
        mul_a = acc_r[33:0];
        mul_b = 18'(mfdf_pkg::SMOOTH_COEF);
      end
      mfdf_pkg::MUL_DEPTH: begin
        mul_a = {2'b00, sd_r};
        mul_b = {2'b00, depth_r};
      end
      mfdf_pkg::MUL_QHI: begin
        // upper half of delay*depth, times the lfo
        mul_a = {10'd0, prod_r[47:24]};
        mul_b = lfo_ext;
      end
      mfdf_pkg::MUL_QLO: begin
        mul_a = {10'd0, lo_r};
        mul_b = lfo_ext;
      end
      mfdf_pkg::MUL_INTERP: begin
        mul_a = {{17{tap_diff[16]}}, tap_diff};
        mul_b = {2'b00, frac_r};
      end
      mfdf_pkg::MUL_FB: begin
        mul_a = {{18{y_r[15]}}, y_r};
        mul_b = {2'b00, gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // ---------------------------------------------------------------- datapath arithmetic
  logic signed [34:0] sd_sum;
  logic [31:0]        sd_nxt;
  logic signed [34:0] rd_dist;
  logic [AW-1:0]      ia_nxt;
  logic signed [16:0] y_sum;
  logic signed [17:0] w_sum;
  logic signed [15:0] w_sat;
  logic signed [16:0] mix_sum;

  always_comb begin
    // smoothed delay plus the floored step, kept within 0 .. 2^32-1
    sd_sum = $signed({3'b000, sd_r}) + $signed(prod_r[50:16]);
    if (sd_sum[34]) begin
      sd_nxt = '0;
    end else if (sd_sum[33:32] != 2'b00) begin
      sd_nxt = '1;
    end else begin
      sd_nxt = sd_sum[31:0];
    end

    // read distance clamps at zero; its integer part wraps on the line depth
    rd_dist = acc_r[34] ? 35'sd0 : acc_r;
    ia_nxt  = wp_r - rd_dist[16+AW-1:16];

    // interpolated tap: a + floor((b - a) * frac / 2^16)
    y_sum = 17'(a_r) + $signed(prod_r[32:16]);

    // feedback word saturates to the sample range
    w_sum = 18'(x_r) + $signed(prod_r[33:16]);
    if (w_sum > 18'sd32767) begin
      w_sat = 16'sh7fff;
    end else if (w_sum < -18'sd32768) begin
      w_sat = 16'sh8000;
    end else begin
      w_sat = w_sum[15:0];
    end

    mix_sum = 17'(x_r) + 17'(y_r);
  end

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r   <= in_ch.sample_in;
      lfo_r <= in_ch.mod_value;
    end

    if (ctl.mul_sel != mfdf_pkg::MUL_OFF) begin
      prod_r <= mul_p;
    end

    case (ctl.acc_op)
      mfdf_pkg::ACC_DIFF:    acc_r <= $signed({3'b000, target_r}) - $signed({3'b000, sd_r});
      mfdf_pkg::ACC_BASE:    acc_r <= $signed({3'b000, sd_r}) + 35'sd65536;
      // add the floored modulation term, mod >> 31
      mfdf_pkg::ACC_ADD_MOD: acc_r <= acc_r + {{2{mod_r[63]}}, mod_r[63:31]};
      default: ;
    endcase

    case (ctl.mod_op)
      mfdf_pkg::MOD_LOAD_HI: mod_r <= {prod_r[39:0], 24'd0};
      mfdf_pkg::MOD_ADD_LO:  mod_r <= mod_r + {{12{prod_r[mfdf_pkg::PROD_W-1]}}, prod_r};
      default: ;
    endcase

    if (ctl.ld_lo) begin
      lo_r <= prod_r[23:0];
    end
    if (ctl.ld_addr) begin
      ia_r   <= ia_nxt;
      frac_r <= rd_dist[15:0];
    end
    if (ctl.ld_a) begin
      a_r <= rdata_r;
    end
    if (ctl.ld_y) begin
      y_r <= y_sum[15:0];
    end
    if (ctl.commit) begin
      out_data_r <= mix_sum[16:1];
    end
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r        <= '0;
      wp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.ld_sd) begin
        sd_r <= sd_nxt;
      end
      if (ctl.mem_op == mfdf_pkg::MEM_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (ctl.commit) begin
        wp_r        <= wp_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- delay line port
  // one port: clearing sweep, two tap reads and the write back take turns
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [15:0]   mem_wdata;

  always_comb begin
    case (ctl.mem_op)
      mfdf_pkg::MEM_CLEAR:  mem_addr = clr_cnt_r;
      mfdf_pkg::MEM_READ_B: mem_addr = ia_r + 1'b1;
      mfdf_pkg::MEM_WRITE:  mem_addr = wp_r + 1'b1;
      default:              mem_addr = ia_r;
    endcase
    mem_we    = (ctl.mem_op == mfdf_pkg::MEM_CLEAR) || (ctl.mem_op == mfdf_pkg::MEM_WRITE);
    mem_wdata = (ctl.mem_op == mfdf_pkg::MEM_WRITE) ? w_sat : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= line_mem[mem_addr];
  end

  // ---------------------------------------------------------------- assertions
  // no input transfer while the line is still being swept
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.mem_op == mfdf_pkg::MEM_CLEAR) |-> !in_ch.ready)
    else $error("input ready during delay line sweep");

  // one sample in flight: ready drops right after a transfer
  a_one_sample_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("second input taken while a sample is in work");

  // the write pointer only moves together with a new result
  a_wp_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(wp_r) |-> out_valid_r)
    else $error("write pointer moved without a result");

endmodule

### bench/modulated_fractional_delay_feedback_tb.sv
// self-checking bench for the flanger delay block: drives samples and register writes
// through the channel interfaces and checks every result against an in-bench predictor
// depends on mfdf_pkg, the interfaces in mfdf_if and the block modulated_fractional_delay_feedback
`timescale 1ns / 100ps

module modulated_fractional_delay_feedback_tb;

  // cycles left after the last result before a register write, so that the block has
  // finished writing back into the delay line
  localparam int SETTLE_CYCLES = 32;
  // quiet-cycle limit: the longest correct silence is the clearing sweep after reset
  // (one word a cycle); the limit is set well above that sweep
  localparam int QUIET_LIMIT   = 4 * mfdf_pkg::LINE_DEPTH + 1000;
  // register indexes past the four real ones, writes there must be dropped
  localparam logic [mfdf_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST =
    mfdf_pkg::CFG_FEEDBACK_GAIN + 1'b1;
  localparam logic [mfdf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

  typedef struct {
    int unsigned       tag;
    logic signed [15:0] sample_out;
  } mix_expect_t;

  logic clk;
  logic rst_n;

  mfdf_in_if  in_ch ();
  mfdf_out_if out_ch ();
  mfdf_cfg_if cfg_ch ();

  modulated_fractional_delay_feedback dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state: delay line, write pointer, smoothed delay and register copies
  logic signed [15:0]           line_mem [0:mfdf_pkg::LINE_DEPTH-1];
  logic [mfdf_pkg::LINE_AW-1:0] wr_ptr;
  logic [31:0]                  smooth_q;
  logic                         cfg_mode;
  logic [31:0]                  cfg_target;
  logic [15:0]                  cfg_depth;
  logic [15:0]                  cfg_gain;

  mix_expect_t pending_mix[$];
  int unsigned sent_count;
  int          mix_errors;
  bit          stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one sample through the flanger: smoothing, read distance (modulated in flanger mode),
  // linear interpolation between two taps, clamped feedback write and the halved dry/wet mix
  function automatic logic signed [15:0] flange_sample(input logic signed [15:0] dry,
                                                       input logic signed [15:0] lfo);
    longint                       pull, glide, reach, tap_a, tap_b, wet, fed, mix;
    logic [mfdf_pkg::LINE_AW-1:0] back, idx_a, idx_b;
    logic [15:0]                  frac;
    // delay creeps toward the target by 66/65536 of the gap, shifts round to minus infinity
    pull  = longint'({32'd0, cfg_target}) - longint'({32'd0, smooth_q});
    glide = longint'({32'd0, smooth_q}) + ((pull * mfdf_pkg::SMOOTH_COEF) >>> 16);
    if (glide < 0) glide = 0;
    if (glide > 64'sh0000_0000_FFFF_FFFF) glide = 64'sh0000_0000_FFFF_FFFF;
    smooth_q = glide[31:0];
    // read distance in Q16.16, one sample behind the write pointer at least
    reach = 64'sd65536 + glide;
    if (cfg_mode == mfdf_pkg::MODE_FLANGER)
      reach += (glide * longint'(lfo) * longint'({48'd0, cfg_depth})) >>> 31;
    if (reach < 0) reach = 0;
    // integer part wraps modulo the line depth, also past one full line
    back  = reach[16 +: mfdf_pkg::LINE_AW];
    frac  = reach[15:0];
    idx_a = wr_ptr - back;
    idx_b = idx_a + 1'b1;
    tap_a = line_mem[idx_a];
    tap_b = line_mem[idx_b];
    wet   = tap_a + (((tap_b - tap_a) * longint'({48'd0, frac})) >>> 16);
    // feedback into the line saturates to Q1.15
    fed = longint'(dry) + ((wet * longint'({48'd0, cfg_gain})) >>> 16);
    if (fed > 32767) fed = 32767;
    if (fed < -32768) fed = -32768;
    wr_ptr = wr_ptr + 1'b1;
    line_mem[wr_ptr] = fed[15:0];
    mix = (longint'(dry) + wet) >>> 1;
    return mix[15:0];
  endfunction

  // random Q1.15 value with the extremes weighted up
  function automatic logic signed [15:0] rand_q15();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // one input transfer, with an optional idle burst in front; valid is left high so the
  // next item can follow straight on
  task automatic push_sample(input logic signed [15:0] dry, input logic signed [15:0] lfo);
    mix_expect_t e;
    if (stall_on && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= dry;
    in_ch.mod_value <= lfo;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    e.tag        = sent_count;
    e.sample_out = flange_sample(dry, lfo);
    pending_mix.push_back(e);
    sent_count++;
  endtask

  // one register write transfer; the predictor keeps only the bits the register holds
  task automatic write_reg(input logic [mfdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mfdf_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      mfdf_pkg::CFG_MODE:          cfg_mode   = val[0];
      mfdf_pkg::CFG_TARGET_DELAY:  cfg_target = val;
      mfdf_pkg::CFG_MOD_DEPTH:     cfg_depth  = val[15:0];
      mfdf_pkg::CFG_FEEDBACK_GAIN: cfg_gain   = val[15:0];
      default: ;
    endcase
  endtask

  // stop sending and wait until every result is in and the write back is done
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic mode, input logic [31:0] target,
                                input logic [15:0] depth, input logic [15:0] gain);
    settle_block();
    write_reg(mfdf_pkg::CFG_MODE, {31'd0, mode});
    write_reg(mfdf_pkg::CFG_TARGET_DELAY, target);
    write_reg(mfdf_pkg::CFG_MOD_DEPTH, {16'd0, depth});
    write_reg(mfdf_pkg::CFG_FEEDBACK_GAIN, {16'd0, gain});
    cfg_ch.valid <= 1'b0;
  endtask

  // reset values: flanger, zero target, default depth and gain, cleared line
  task automatic test_cleared_line();
    push_sample(16'sd0, 16'sd0);
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(-16'sd1, -16'sd1);
    push_sample(16'sd1, 16'sd1);
  endtask

  // bits above each register's width are dropped, spare indexes change nothing,
  // zero depth and zero gain in both modes
  task automatic test_register_fields();
    settle_block();
    write_reg(mfdf_pkg::CFG_MODE, 32'hFFFF_FFFF);
    write_reg(mfdf_pkg::CFG_TARGET_DELAY, 32'h0004_8000);
    write_reg(mfdf_pkg::CFG_MOD_DEPTH, 32'hFFFF_0000);
    write_reg(mfdf_pkg::CFG_FEEDBACK_GAIN, 32'h5A5A_0000);
    write_reg(CFG_SPARE_FIRST, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_LAST, 32'h0000_0001);
    cfg_ch.valid <= 1'b0;
    push_sample(16'sh7FFF, 16'sh8000);
    push_sample(16'sh8000, 16'sh7FFF);
    push_sample(16'sd12345, 16'sd0);
    push_sample(-16'sd4321, 16'sh7FFF);
    settle_block();
    // flanger again but with zero depth, so the modulation has no effect
    write_reg(mfdf_pkg::CFG_MODE, 32'hFFFF_FFFE);
    cfg_ch.valid <= 1'b0;
    push_sample(16'sh7FFF, 16'sh7FFF);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sd0, 16'sh7FFF);
  endtask

  // full gain on a constant full-scale input drives the stored word into saturation
  task automatic test_feedback_clamp();
    apply_settings(mfdf_pkg::MODE_PLAIN, 32'd0, 16'hFFFF, 16'hFFFF);
    repeat (6) push_sample(16'sh7FFF, rand_q15());
    repeat (6) push_sample(16'sh8000, rand_q15());
  endtask

  // maximum target and depth: the smoothing constant is about a thousand transfers, so
  // it takes several hundred before modulation carries the read distance past the line
  // depth and the tap indices wrap
  task automatic test_long_sweep();
    apply_settings(mfdf_pkg::MODE_FLANGER, 32'hFFFF_FFFF, 16'hFFFF, 16'($urandom()));
    repeat (750) push_sample(rand_q15(), rand_q15());
  endtask

  // a run of random settings, extremes included, with random content under each
  task automatic test_random_settings();
    logic        mode;
    logic [31:0] target;
    logic [15:0] depth, gain;
    repeat (8) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: target = 32'd0;
        1: target = $urandom_range(0, 32'h0040_0000);
        2: target = $urandom();
        default: target = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 2))
        0: depth = 16'd0;
        1: depth = 16'hFFFF;
        default: depth = 16'($urandom());
      endcase
      case ($urandom_range(0, 2))
        0: gain = 16'd0;
        1: gain = 16'hFFFF;
        default: gain = 16'($urandom());
      endcase
      apply_settings(mode, target, depth, gain);
      repeat (100) push_sample(rand_q15(), rand_q15());
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_quiet_tail();
    stall_on = 1'b0;
    repeat (100) push_sample(rand_q15(), rand_q15());
  endtask

  // result side: ready dropped in random bursts while stalling is enabled
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // every result transfer is matched against the oldest outstanding expectation
  always @(posedge clk) begin
    mix_expect_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_mix.size() == 0) begin
        $display("%0t: sample_out %0d arrived with nothing outstanding", $time,
                 out_ch.sample_out);
        mix_errors++;
      end else begin
        want = pending_mix.pop_front();
        if (out_ch.sample_out !== want.sample_out) begin
          $display("%0t: item %0d sample_out expected %0d, got %0d", $time, want.tag,
                   want.sample_out, out_ch.sample_out);
          mix_errors++;
        end
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    // all block inputs known from time zero
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    in_ch.mod_value <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    stall_on   = 1'b1;
    sent_count = 0;
    mix_errors = 0;
    // predictor at its reset state
    for (int k = 0; k < mfdf_pkg::LINE_DEPTH; k++) line_mem[k] = '0;
    wr_ptr     = '0;
    smooth_q   = '0;
    cfg_mode   = mfdf_pkg::MODE_FLANGER;
    cfg_target = '0;
    cfg_depth  = mfdf_pkg::MOD_DEPTH_RST;
    cfg_gain   = mfdf_pkg::FB_GAIN_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // the first transfer waits out the clearing sweep on input ready
    test_cleared_line();
    test_register_fields();
    test_feedback_clamp();
    test_long_sweep();
    test_random_settings();
    test_quiet_tail();

    settle_block();
    if (mix_errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/mfdf_pkg.sv
rtl/mfdf_if.sv
rtl/mfdf_seq.sv
rtl/modulated_fractional_delay_feedback.sv
bench/modulated_fractional_delay_feedback_tb.sv
